FILE: src/vbdma_pkg.sv
// vbdma_pkg: types and constants for the VRAM block DMA controller.
// Used by vbdma_apb, vbdma_core and vram_block_dma_controller.
package vbdma_pkg;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_BLANK = 2'd2;

    localparam logic [2:0] REG_SRC_HI = 3'd0;
    localparam logic [2:0] REG_SRC_LO = 3'd1;
    localparam logic [2:0] REG_DST_HI = 3'd2;
    localparam logic [2:0] REG_DST_LO = 3'd3;
    localparam logic [2:0] REG_CTRL   = 3'd4;

    localparam logic        CFG_COLOR_MODE = 1'b0;
    localparam logic        COLOR_MODE_RST = 1'b1;

    localparam logic [15:0] SRC_ALIGN  = 16'hFFF0;
    localparam logic [12:0] DST_ALIGN  = 13'h1FF0;
    localparam logic [15:0] BLOCK_SIZE = 16'h0010;
    localparam logic [7:0]  READ_NONE  = 8'hFF;

    typedef struct packed {
        logic [1:0] cmd;
        logic [2:0] reg_sel;
        logic [7:0] wdata;
    } t_item;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        xfer_valid;
        logic [15:0] xfer_src;
        logic [12:0] xfer_dst;
        logic [7:0]  xfer_blocks;
        logic        busy_res;
    } t_result;

endpackage

FILE: src/vram_block_dma_controller.sv
// vram_block_dma_controller: top level, input beat register, core, result register.
// Depends on vbdma_pkg, vbdma_apb, vbdma_core.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+------------------------------------
//  item in  | in        | i_in_valid / o_in_stall | i_cmd, i_reg_sel, i_wdata
//  result   | out       | o_out_valid/i_out_stall | o_read_data, o_xfer_*, o_busy_res
//  config   | in        | APB psel/penable/pready | paddr, pwdata, prdata
//
// One beat per cycle sustained while the result register is not stalled.
// State is updated as a beat leaves the input register for the result register.
// A stalled result holds; the input register keeps taking beats while the result
// register is free or being drained. Sync active-low reset clears all but data regs.
module vram_block_dma_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_cmd,
    input  logic [2:0]  i_reg_sel,
    input  logic [7:0]  i_wdata,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_read_data,
    output logic        o_xfer_valid,
    output logic [15:0] o_xfer_src,
    output logic [12:0] o_xfer_dst,
    output logic [7:0]  o_xfer_blocks,
    output logic        o_busy_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import vbdma_pkg::*;

    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_res;
    t_result w_res;
    logic    w_color_mode;
    logic    w_out_free;
    logic    w_advance;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_advance  = r_in_valid && w_out_free;
    assign o_in_stall = r_in_valid && !w_out_free;

    vbdma_apb u_apb (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_color_mode (w_color_mode)
    );

    vbdma_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (w_advance),
        .i_color_mode (w_color_mode),
        .i_item       (r_item),
        .o_result     (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (w_out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_item <= '{cmd: i_cmd, reg_sel: i_reg_sel, wdata: i_wdata};
        end
        if (w_advance) begin
            r_res <= w_res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_read_data   = r_res.read_data;
    assign o_xfer_valid  = r_res.xfer_valid;
    assign o_xfer_src    = r_res.xfer_src;
    assign o_xfer_dst    = r_res.xfer_dst;
    assign o_xfer_blocks = r_res.xfer_blocks;
    assign o_busy_res    = r_res.busy_res;

endmodule

FILE: src/vbdma_apb.sv
// vbdma_apb: APB register port holding the color_mode bit.
// Depends on vbdma_pkg.
module vbdma_apb (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic        o_color_mode
);
    import vbdma_pkg::*;

    logic r_color_mode;
    logic w_sel_mode;

    assign w_sel_mode = (paddr[2] == CFG_COLOR_MODE);
    assign pready     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_mode <= COLOR_MODE_RST;
        end else if (psel && penable && pwrite && pready && w_sel_mode) begin
            r_color_mode <= pwdata[0];
        end
    end

    assign prdata       = w_sel_mode ? {31'b0, r_color_mode} : 32'b0;
    assign o_color_mode = r_color_mode;

endmodule

FILE: src/vbdma_core.sv
// vbdma_core: transfer state and combinational item evaluation.
// Depends on vbdma_pkg.
module vbdma_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  logic              i_color_mode,
    input  vbdma_pkg::t_item   i_item,
    output vbdma_pkg::t_result o_result
);
    import vbdma_pkg::*;

    logic [15:0] r_lat_src, n_lat_src;
    logic [15:0] r_lat_dst, n_lat_dst;
    logic [15:0] r_cur_src, n_cur_src;
    logic [12:0] r_cur_dst, n_cur_dst;
    logic [7:0]  r_blocks,  n_blocks;
    logic        r_running, n_running;

    always_comb begin
        logic [15:0] start_src;
        logic [12:0] start_dst;
        logic [7:0]  count;
        logic [11:0] span;
        logic [7:0]  left_m1;

        n_lat_src = r_lat_src;
        n_lat_dst = r_lat_dst;
        n_cur_src = r_cur_src;
        n_cur_dst = r_cur_dst;
        n_blocks  = r_blocks;
        n_running = r_running;
        o_result  = '0;

        start_src = r_lat_src & SRC_ALIGN;
        start_dst = r_lat_dst[12:0] & DST_ALIGN;
        count     = {1'b0, i_item.wdata[6:0]} + 8'd1;
        span      = {count, 4'b0000};
        left_m1   = r_blocks - 8'd1;

        unique case (i_item.cmd)
            CMD_WRITE: begin
                if (i_color_mode) begin
                    case (i_item.reg_sel)
                        REG_SRC_HI: n_lat_src = {i_item.wdata, r_lat_src[7:0]};
                        REG_SRC_LO: n_lat_src = {r_lat_src[15:8], i_item.wdata};
                        REG_DST_HI: n_lat_dst = {i_item.wdata, r_lat_dst[7:0]};
                        REG_DST_LO: n_lat_dst = {r_lat_dst[15:8], i_item.wdata};
                        REG_CTRL: begin
                            if (!i_item.wdata[7] && r_running) begin
                                n_running = 1'b0;
                            end else if (i_item.wdata[7]) begin
                                n_cur_src = start_src;
                                n_cur_dst = start_dst;
                                n_blocks  = count;
                                n_running = 1'b1;
                            end else begin
                                // general-purpose copy: one descriptor for all blocks
                                n_cur_src            = start_src + {4'b0, span};
                                n_cur_dst            = start_dst + {1'b0, span};
                                n_blocks             = 8'd0;
                                n_running            = 1'b0;
                                o_result.xfer_valid  = 1'b1;
                                o_result.xfer_src    = start_src;
                                o_result.xfer_dst    = start_dst;
                                o_result.xfer_blocks = count;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            CMD_READ: begin
                o_result.read_data = READ_NONE;
                if (i_color_mode && i_item.reg_sel == REG_CTRL) begin
                    o_result.read_data = {~r_running, left_m1[6:0]};
                end
            end
            CMD_BLANK: begin
                if (r_running) begin
                    n_cur_src            = r_cur_src + BLOCK_SIZE;
                    n_cur_dst            = r_cur_dst + BLOCK_SIZE[12:0];
                    n_blocks             = left_m1;
                    n_running            = (left_m1 != 8'd0);
                    o_result.xfer_valid  = 1'b1;
                    o_result.xfer_src    = r_cur_src;
                    o_result.xfer_dst    = r_cur_dst;
                    o_result.xfer_blocks = 8'd1;
                end
            end
            default: ;
        endcase

        o_result.busy_res = n_running;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lat_src <= '0;
            r_lat_dst <= '0;
            r_cur_src <= '0;
            r_cur_dst <= '0;
            r_blocks  <= '0;
            r_running <= 1'b0;
        end else if (i_advance) begin
            r_lat_src <= n_lat_src;
            r_lat_dst <= n_lat_dst;
            r_cur_src <= n_cur_src;
            r_cur_dst <= n_cur_dst;
            r_blocks  <= n_blocks;
            r_running <= n_running;
        end
    end

endmodule

FILE: src/vbdma_checker.sv
// vbdma_checker: port-level assertions for vram_block_dma_controller, with bind.
// Depends on the top level's ports only.
module vbdma_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [7:0]  o_read_data,
    input logic        o_xfer_valid,
    input logic [15:0] o_xfer_src,
    input logic [12:0] o_xfer_dst,
    input logic [7:0]  o_xfer_blocks
);

    a_blocks_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_xfer_valid |-> o_xfer_blocks != 8'd0 && o_xfer_blocks <= 8'd128)
        else $error("descriptor block count out of range");

    a_idle_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_xfer_valid |->
            o_xfer_src == 16'd0 && o_xfer_dst == 13'd0 && o_xfer_blocks == 8'd0)
        else $error("descriptor fields set without a descriptor");

    a_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_xfer_valid |->
            o_xfer_src[3:0] == 4'd0 && o_xfer_dst[3:0] == 4'd0 && o_read_data == 8'd0)
        else $error("descriptor misaligned or carries read data");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_xfer_src)
            && $stable(o_read_data) && $stable(o_xfer_blocks))
        else $error("stalled result beat changed");

endmodule

bind vram_block_dma_controller vbdma_checker u_vbdma_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_read_data   (o_read_data),
    .o_xfer_valid  (o_xfer_valid),
    .o_xfer_src    (o_xfer_src),
    .o_xfer_dst    (o_xfer_dst),
    .o_xfer_blocks (o_xfer_blocks)
);

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for vram_block_dma_controller.
// Drives item beats and APB config writes, predicts every result in-line and
// checks it field by field. Depends on vbdma_pkg and the controller RTL.
module testbench;
    import vbdma_pkg::*;

    localparam int          CYCLE_LIMIT     = 400000;
    localparam logic [1:0]  CMD_NONE        = 2'd3;
    localparam logic [2:0]  REG_UNUSED      = 3'd7;
    localparam logic [2:0]  ADDR_COLOR_MODE = {CFG_COLOR_MODE, 2'b00};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_cmd = CMD_READ;
    logic [2:0]  i_reg_sel = REG_CTRL;
    logic [7:0]  i_wdata = 8'h00;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [7:0]  o_read_data;
    logic        o_xfer_valid;
    logic [15:0] o_xfer_src;
    logic [12:0] o_xfer_dst;
    logic [7:0]  o_xfer_blocks;
    logic        o_busy_res;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    vram_block_dma_controller dut (.*);

    always #6 i_clk = ~i_clk;

    // predicted controller state
    logic        mdl_color = COLOR_MODE_RST;
    logic [15:0] lat_src = '0;
    logic [15:0] lat_dst = '0;
    logic [15:0] cur_src = '0;
    logic [12:0] cur_dst = '0;
    logic [7:0]  left_blocks = '0;
    logic        xfer_running = 1'b0;

    t_result copy_expect[$];
    int      error_count = 0;
    int      cycle_count = 0;
    int      send_gap_max = 11;
    int      sink_gap_max = 11;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("vram_block_dma_controller test failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR at %0t: %s got %0h want %0h", $time, what, got, want);
        error_count++;
    endtask

    function automatic t_result dma_predict(input logic [1:0] cmd, input logic [2:0] sel,
                                            input logic [7:0] v);
        t_result r;
        r = '0;
        case (cmd)
            CMD_WRITE: if (mdl_color) begin
                case (sel)
                    REG_SRC_HI: lat_src[15:8] = v;
                    REG_SRC_LO: lat_src[7:0] = v;
                    REG_DST_HI: lat_dst[15:8] = v;
                    REG_DST_LO: lat_dst[7:0] = v;
                    REG_CTRL: begin
                        if (!v[7] && xfer_running) begin
                            xfer_running = 1'b0;
                        end else begin
                            cur_src = lat_src & SRC_ALIGN;
                            cur_dst = lat_dst[12:0] & DST_ALIGN;
                            left_blocks = {1'b0, v[6:0]} + 8'd1;
                            xfer_running = v[7];
                            if (!xfer_running) begin
                                r.xfer_valid = 1'b1;
                                r.xfer_src = cur_src;
                                r.xfer_dst = cur_dst;
                                r.xfer_blocks = left_blocks;
                                cur_src = cur_src + {4'h0, left_blocks, 4'h0};
                                cur_dst = cur_dst + {1'b0, left_blocks, 4'h0};
                                left_blocks = '0;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            CMD_READ: begin
                r.read_data = READ_NONE;
                if (mdl_color && sel == REG_CTRL)
                    r.read_data = {~xfer_running, left_blocks[6:0] - 7'd1};
            end
            CMD_BLANK: if (xfer_running) begin
                r.xfer_valid = 1'b1;
                r.xfer_src = cur_src;
                r.xfer_dst = cur_dst;
                r.xfer_blocks = 8'd1;
                cur_src = cur_src + BLOCK_SIZE;
                cur_dst = cur_dst + BLOCK_SIZE[12:0];
                left_blocks = left_blocks - 8'd1;
                if (left_blocks == 8'd0)
                    xfer_running = 1'b0;
            end
            default: ;
        endcase
        r.busy_res = xfer_running;
        return r;
    endfunction

    // valid stays high across back-to-back beats; lowered only for a gap
    task automatic send_beat(input logic [1:0] cmd, input logic [2:0] sel,
                             input logic [7:0] v);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd <= cmd;
        i_reg_sel <= sel;
        i_wdata <= v;
        do @(posedge i_clk); while (o_in_stall);
        copy_expect.push_back(dma_predict(cmd, sel, v));
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (copy_expect.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic set_color_mode(input logic mode);
        settle();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_COLOR_MODE;
        pwdata <= {31'd0, mode};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        mdl_color = mode;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {31'd0, mode})
            report_mismatch("color_mode readback", prdata, {31'd0, mode});
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_result();
        t_result want;
        if (copy_expect.size() == 0) begin
            report_mismatch("result with nothing expected", 32'(o_read_data), 32'd0);
            return;
        end
        want = copy_expect.pop_front();
        if (o_read_data !== want.read_data)
            report_mismatch("read_data", 32'(o_read_data), 32'(want.read_data));
        if (o_xfer_valid !== want.xfer_valid)
            report_mismatch("xfer_valid", 32'(o_xfer_valid), 32'(want.xfer_valid));
        if (o_xfer_src !== want.xfer_src)
            report_mismatch("xfer_src", 32'(o_xfer_src), 32'(want.xfer_src));
        if (o_xfer_dst !== want.xfer_dst)
            report_mismatch("xfer_dst", 32'(o_xfer_dst), 32'(want.xfer_dst));
        if (o_xfer_blocks !== want.xfer_blocks)
            report_mismatch("xfer_blocks", 32'(o_xfer_blocks), 32'(want.xfer_blocks));
        if (o_busy_res !== want.busy_res)
            report_mismatch("busy_res", 32'(o_busy_res), 32'(want.busy_res));
    endtask

    // result side: stall drawn per beat, then take the next valid result
    initial begin : result_sink
        int hold;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            hold = $urandom_range(0, sink_gap_max);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            check_result();
        end
    end

    task automatic test_reset_status();
        send_beat(CMD_READ, REG_CTRL, 8'h00);
        send_beat(CMD_READ, REG_UNUSED, 8'h00);
        send_beat(CMD_WRITE, REG_UNUSED, 8'hFF);
        send_beat(CMD_BLANK, REG_CTRL, 8'h00);
        send_beat(CMD_NONE, REG_CTRL, 8'hFF);
    endtask

    task automatic test_general_copy();
        send_beat(CMD_WRITE, REG_SRC_HI, 8'hFF);
        send_beat(CMD_WRITE, REG_SRC_LO, 8'hFF);
        send_beat(CMD_WRITE, REG_DST_HI, 8'hFF);
        send_beat(CMD_WRITE, REG_DST_LO, 8'hFF);
        send_beat(CMD_WRITE, REG_CTRL, 8'h7F);
        send_beat(CMD_READ, REG_CTRL, 8'h00);
        send_beat(CMD_WRITE, REG_CTRL, 8'h00);
    endtask

    // addresses still at the top: blocks wrap to zero
    task automatic test_blank_paced();
        send_beat(CMD_WRITE, REG_CTRL, 8'h81);
        send_beat(CMD_BLANK, REG_CTRL, 8'h00);
        send_beat(CMD_READ, REG_CTRL, 8'h00);
        send_beat(CMD_BLANK, REG_CTRL, 8'h00);
        send_beat(CMD_BLANK, REG_CTRL, 8'h00);
    endtask

    task automatic test_stop_restart();
        send_beat(CMD_WRITE, REG_CTRL, 8'hFF);
        send_beat(CMD_BLANK, REG_CTRL, 8'h00);
        send_beat(CMD_WRITE, REG_CTRL, 8'h00);
        send_beat(CMD_READ, REG_CTRL, 8'h00);
        send_beat(CMD_WRITE, REG_CTRL, 8'h80);
        send_beat(CMD_WRITE, REG_CTRL, 8'h85);
        send_beat(CMD_WRITE, REG_CTRL, 8'h05);
    endtask

    task automatic test_color_mode();
        send_beat(CMD_WRITE, REG_CTRL, 8'h81);
        set_color_mode(1'b0);
        send_beat(CMD_WRITE, REG_SRC_HI, 8'h12);
        send_beat(CMD_WRITE, REG_CTRL, 8'h00);
        send_beat(CMD_READ, REG_CTRL, 8'h00);
        send_beat(CMD_BLANK, REG_CTRL, 8'h00);
        send_beat(CMD_BLANK, REG_CTRL, 8'h00);
        set_color_mode(1'b1);
        send_beat(CMD_READ, REG_CTRL, 8'h00);
    endtask

    task automatic test_random_traffic();
        int pick;
        logic [1:0] cmd;
        logic [2:0] sel;
        logic [7:0] v;
        for (int phase = 0; phase < 6; phase++) begin
            set_color_mode(phase % 3 != 2);
            for (int n = 0; n < 300; n++) begin
                if (n % 60 == 0) begin
                    send_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 11;
                    sink_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 11;
                end
                pick = $urandom_range(0, 99);
                v = 8'($urandom_range(0, 255));
                if (pick < 30) begin
                    cmd = CMD_BLANK;
                    sel = 3'($urandom_range(0, 7));
                end else if (pick < 45) begin
                    cmd = CMD_READ;
                    sel = ($urandom_range(0, 3) != 0) ? REG_CTRL : 3'($urandom_range(0, 7));
                end else if (pick < 72) begin
                    cmd = CMD_WRITE;
                    sel = 3'($urandom_range(0, 3));
                end else if (pick < 90) begin
                    // mostly short transfers so paced ones run to the end
                    cmd = CMD_WRITE;
                    sel = REG_CTRL;
                    v[6:0] = ($urandom_range(0, 9) < 8) ? 7'($urandom_range(0, 7))
                                                        : 7'($urandom_range(0, 127));
                end else begin
                    cmd = 2'($urandom_range(0, 3));
                    sel = 3'($urandom_range(0, 7));
                end
                send_beat(cmd, sel, v);
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_status();
        test_general_copy();
        test_blank_paced();
        test_stop_restart();
        test_color_mode();
        test_random_traffic();
        settle();
        if (error_count == 0)
            $display("vram_block_dma_controller test passed");
        else
            $display("vram_block_dma_controller test failed");
        $finish;
    end

endmodule
